// File: sv/rrts_pkg.sv
// shared types and codes for the round-robin task scheduler
// used by rrts_seq and round_robin_task_scheduler
package rrts_pkg;

   localparam int SLOTS_DEFAULT = 16;

   localparam int FUNC_W = 2;
   localparam int CTX_W = 32;
   localparam int STATUS_W = 3;
   localparam int SLOT_OUT_W = 4;
   localparam int SLOT_ST_W = 2;

   // operations
   localparam logic [FUNC_W-1:0] FUNC_CREATE = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_YIELD = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_EXIT = 2'd2;

   // result status codes
   localparam logic [STATUS_W-1:0] RES_SWITCH = 3'd0;
   localparam logic [STATUS_W-1:0] RES_STAY = 3'd1;
   localparam logic [STATUS_W-1:0] RES_IDLE = 3'd2;
   localparam logic [STATUS_W-1:0] RES_CREATED = 3'd3;
   localparam logic [STATUS_W-1:0] RES_FULL = 3'd4;

   // per-slot state
   localparam logic [SLOT_ST_W-1:0] SLOT_TERM = 2'd0;
   localparam logic [SLOT_ST_W-1:0] SLOT_READY = 2'd1;
   localparam logic [SLOT_ST_W-1:0] SLOT_CUR = 2'd2;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic old_valid;
      logic [SLOT_OUT_W-1:0] old_slot;
      logic [SLOT_OUT_W-1:0] new_slot;
      logic [CTX_W-1:0] new_context;
   } result_type;

endpackage

// File: sv/rrts_ram.sv
// simple dual-port synchronous ram, one write and one registered read port
// no dependencies
module rrts_ram #(
   parameter int WIDTH = 2,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/rrts_seq.sv
// sequencer of the task scheduler: operation decode, slot scan, write-back
// depends on rrts_pkg; drives the status and context rams in the top level
module rrts_seq #(
   parameter int SLOTS = rrts_pkg::SLOTS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   // operation beat
   input  logic                          op_valid,
   output logic                          op_ready,
   input  logic [rrts_pkg::FUNC_W-1:0]   op_func,
   input  logic [rrts_pkg::CTX_W-1:0]    op_context,
   // status ram
   output logic                          st_wr_en,
   output logic [$clog2(SLOTS)-1:0]      st_wr_addr,
   output logic [rrts_pkg::SLOT_ST_W-1:0] st_wr_data,
   output logic                          st_rd_en,
   output logic [$clog2(SLOTS)-1:0]      st_rd_addr,
   input  logic [rrts_pkg::SLOT_ST_W-1:0] st_rd_data,
   // context ram
   output logic                          ctx_wr_en,
   output logic [$clog2(SLOTS)-1:0]      ctx_wr_addr,
   output logic [rrts_pkg::CTX_W-1:0]    ctx_wr_data,
   output logic                          ctx_rd_en,
   output logic [$clog2(SLOTS)-1:0]      ctx_rd_addr,
   input  logic [rrts_pkg::CTX_W-1:0]    ctx_rd_data,
   // result
   output logic                          res_valid,
   input  logic                          res_take,
   output rrts_pkg::result_type          res
);

   localparam int IW = $clog2(SLOTS);
   localparam int CW = $clog2(SLOTS + 1);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_SCAN = 3'd1;
   localparam logic [2:0] S_WB = 3'd2;
   localparam logic [2:0] S_WB2 = 3'd3;
   localparam logic [2:0] S_OUT = 3'd4;

   localparam logic [1:0] SEL_ZERO = 2'd0;
   localparam logic [1:0] SEL_WORD = 2'd1;
   localparam logic [1:0] SEL_MEM = 2'd2;

   // control
   logic [2:0]    state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic          has_cur_ff, has_cur_in;
   logic [IW-1:0] cur_idx_ff, cur_idx_in;
   logic [CW-1:0] remain_ff, remain_in;
   logic          rd_pend_ff, rd_pend_in;
   logic          rd_last_ff, rd_last_in;
   // item payload
   logic          had_ff, had_in;
   logic          exit_ff, exit_in;
   logic [IW-1:0] cur_ff, cur_in;
   logic [rrts_pkg::CTX_W-1:0] cw_ff, cw_in;
   logic [IW-1:0] scan_idx_ff, scan_idx_in;
   logic [IW-1:0] rd_idx_ff, rd_idx_in;
   logic [IW-1:0] next_ff, next_in;
   logic [rrts_pkg::STATUS_W-1:0] res_status_ff, res_status_in;
   logic [IW-1:0] res_new_ff, res_new_in;
   logic [1:0]    sel_ff, sel_in;

   logic [IW-1:0] cur_wrap;
   logic [IW-1:0] scan_wrap;

   // successor in the created range, wrapping at the fill count
   assign cur_wrap = (CW'(cur_idx_ff) == count_ff - CW'(1)) ? '0 : cur_idx_ff + IW'(1);
   assign scan_wrap = (CW'(scan_idx_ff) == count_ff - CW'(1)) ? '0 : scan_idx_ff + IW'(1);

   assign op_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      has_cur_in = has_cur_ff;
      cur_idx_in = cur_idx_ff;
      remain_in = remain_ff;
      rd_pend_in = rd_pend_ff;
      rd_last_in = rd_last_ff;
      had_in = had_ff;
      exit_in = exit_ff;
      cur_in = cur_ff;
      cw_in = cw_ff;
      scan_idx_in = scan_idx_ff;
      rd_idx_in = rd_idx_ff;
      next_in = next_ff;
      res_status_in = res_status_ff;
      res_new_in = res_new_ff;
      sel_in = sel_ff;
      st_wr_en = 1'b0;
      st_wr_addr = cur_ff;
      st_wr_data = rrts_pkg::SLOT_TERM;
      st_rd_en = 1'b0;
      st_rd_addr = scan_idx_ff;
      ctx_wr_en = 1'b0;
      ctx_wr_addr = IW'(count_ff);
      ctx_wr_data = op_context;
      ctx_rd_en = 1'b0;
      ctx_rd_addr = next_ff;
      res_valid = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (op_valid) begin
               had_in = has_cur_ff;
               exit_in = (op_func == rrts_pkg::FUNC_EXIT) && has_cur_ff;
               cur_in = cur_idx_ff;
               cw_in = op_context;
               if (op_func == rrts_pkg::FUNC_CREATE) begin
                  if (count_ff >= CW'(SLOTS)) begin
                     res_status_in = rrts_pkg::RES_FULL;
                     res_new_in = '0;
                     sel_in = SEL_ZERO;
                  end else begin
                     ctx_wr_en = 1'b1;
                     st_wr_en = 1'b1;
                     st_wr_addr = IW'(count_ff);
                     st_wr_data = rrts_pkg::SLOT_READY;
                     count_in = count_ff + CW'(1);
                     res_status_in = rrts_pkg::RES_CREATED;
                     res_new_in = IW'(count_ff);
                     sel_in = SEL_WORD;
                  end
                  state_in = S_OUT;
               end else if (count_ff == '0) begin
                  res_status_in = rrts_pkg::RES_IDLE;
                  res_new_in = '0;
                  sel_in = SEL_ZERO;
                  state_in = S_OUT;
               end else begin
                  if ((op_func == rrts_pkg::FUNC_EXIT) && has_cur_ff) begin
                     st_wr_en = 1'b1;
                     st_wr_addr = cur_idx_ff;
                     st_wr_data = rrts_pkg::SLOT_TERM;
                  end
                  scan_idx_in = has_cur_ff ? cur_wrap : '0;
                  remain_in = count_ff;
                  rd_pend_in = 1'b0;
                  rd_last_in = 1'b0;
                  state_in = S_SCAN;
               end
            end
         end
         S_SCAN: begin
            rd_pend_in = 1'b0;
            if (rd_pend_ff && (st_rd_data == rrts_pkg::SLOT_READY)) begin
               next_in = rd_idx_ff;
               state_in = S_WB;
            end else if (rd_pend_ff && rd_last_ff) begin
               if (had_ff && !exit_ff) begin
                  ctx_rd_en = 1'b1;
                  ctx_rd_addr = cur_ff;
                  res_status_in = rrts_pkg::RES_STAY;
                  res_new_in = cur_ff;
                  sel_in = SEL_MEM;
               end else begin
                  if (exit_ff) begin
                     has_cur_in = 1'b0;
                  end
                  res_status_in = rrts_pkg::RES_IDLE;
                  res_new_in = '0;
                  sel_in = SEL_ZERO;
               end
               state_in = S_OUT;
            end else if (remain_ff != '0) begin
               st_rd_en = 1'b1;
               rd_pend_in = 1'b1;
               rd_idx_in = scan_idx_ff;
               rd_last_in = (remain_ff == CW'(1));
               scan_idx_in = scan_wrap;
               remain_in = remain_ff - CW'(1);
            end
         end
         S_WB: begin
            st_wr_en = 1'b1;
            st_wr_addr = next_ff;
            st_wr_data = rrts_pkg::SLOT_CUR;
            ctx_rd_en = 1'b1;
            ctx_rd_addr = next_ff;
            has_cur_in = 1'b1;
            cur_idx_in = next_ff;
            res_status_in = rrts_pkg::RES_SWITCH;
            res_new_in = next_ff;
            sel_in = SEL_MEM;
            state_in = (had_ff && !exit_ff) ? S_WB2 : S_OUT;
         end
         S_WB2: begin
            st_wr_en = 1'b1;
            st_wr_addr = cur_ff;
            st_wr_data = rrts_pkg::SLOT_READY;
            state_in = S_OUT;
         end
         S_OUT: begin
            res_valid = 1'b1;
            if (res_take) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      res.status = res_status_ff;
      res.old_valid = had_ff;
      res.old_slot = had_ff ? rrts_pkg::SLOT_OUT_W'(cur_ff) : '0;
      res.new_slot = rrts_pkg::SLOT_OUT_W'(res_new_ff);
      case (sel_ff)
         SEL_WORD: res.new_context = cw_ff;
         SEL_MEM:  res.new_context = ctx_rd_data;
         default:  res.new_context = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         count_ff <= '0;
         has_cur_ff <= 1'b0;
         cur_idx_ff <= '0;
         remain_ff <= '0;
         rd_pend_ff <= 1'b0;
         rd_last_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         has_cur_ff <= has_cur_in;
         cur_idx_ff <= cur_idx_in;
         remain_ff <= remain_in;
         rd_pend_ff <= rd_pend_in;
         rd_last_ff <= rd_last_in;
      end
   end

   always_ff @(posedge clock) begin
      had_ff <= had_in;
      exit_ff <= exit_in;
      cur_ff <= cur_in;
      cw_ff <= cw_in;
      scan_idx_ff <= scan_idx_in;
      rd_idx_ff <= rd_idx_in;
      next_ff <= next_in;
      res_status_ff <= res_status_in;
      res_new_ff <= res_new_in;
      sel_ff <= sel_in;
   end

   // fill count never passes the table size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(SLOTS))
      else $error("created slot count above table size");

   // the current slot always lies in the created range
   a_cur_created: assert property (@(posedge clock) disable iff (reset)
      has_cur_ff |-> (CW'(cur_idx_ff) < count_ff))
      else $error("current slot outside created range");

   // a scan only runs over a non-empty table
   a_scan_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> (count_ff != '0))
      else $error("scan with no created slots");

   // status ram is never written while a scan read is in flight
   a_scan_no_write: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN) |-> !st_wr_en)
      else $error("status write during scan");

   // a switch always lands on the slot found by the scan
   a_switch_target: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WB) |=> (has_cur_ff && (cur_idx_ff == $past(next_ff))))
      else $error("switch did not update the current slot");

endmodule

// File: sv/round_robin_task_scheduler.sv
// Round-robin task scheduler: a table of task slots, each with a state
// (terminated, ready, current) and a 32-bit context word, kept in two small
// synchronous rams. One operation beat goes in (create, yield or exit) and
// exactly one result beat comes out. Create fills the next unused slot, or
// reports a full table. Yield and exit walk the created slots round-robin
// from the one after the current slot (from slot 0 when there is none), one
// status-ram read per cycle. Only one operation is in work at a time; the
// output register lets the next operation be taken while a result beat still
// waits on rsp_tready. The rams need no clearing pass after reset: the
// created-slot count marks which entries hold valid data.
// depends on rrts_pkg, rrts_ram and rrts_seq
module round_robin_task_scheduler #(
   parameter int SLOTS = rrts_pkg::SLOTS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // operation channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] context_word
   input  logic [7:0]  req_tuser,   // [1:0] func, zeros above
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // [0] old_valid, [4:1] old_slot,
                                    // [8:5] new_slot, [40:9] new_context
   output logic [7:0]  rsp_tuser    // [2:0] status, zeros above
);

   localparam int IW = $clog2(SLOTS);

   // status ram port
   logic                           st_wr_en;
   logic [IW-1:0]                  st_wr_addr;
   logic [rrts_pkg::SLOT_ST_W-1:0] st_wr_data;
   logic                           st_rd_en;
   logic [IW-1:0]                  st_rd_addr;
   logic [rrts_pkg::SLOT_ST_W-1:0] st_rd_data;
   // context ram port
   logic                           ctx_wr_en;
   logic [IW-1:0]                  ctx_wr_addr;
   logic [rrts_pkg::CTX_W-1:0]     ctx_wr_data;
   logic                           ctx_rd_en;
   logic [IW-1:0]                  ctx_rd_addr;
   logic [rrts_pkg::CTX_W-1:0]     ctx_rd_data;

   logic                 res_valid;
   logic                 res_take;
   rrts_pkg::result_type res;

   // output register
   logic                 out_valid_ff, out_valid_in;
   rrts_pkg::result_type out_ff, out_in;

   // slot state table
   rrts_ram #(
      .WIDTH (rrts_pkg::SLOT_ST_W),
      .DEPTH (SLOTS)
   ) u_status_ram (
      .clock   (clock),
      .wr_en   (st_wr_en),
      .wr_addr (st_wr_addr),
      .wr_data (st_wr_data),
      .rd_en   (st_rd_en),
      .rd_addr (st_rd_addr),
      .rd_data (st_rd_data)
   );

   // context word table
   rrts_ram #(
      .WIDTH (rrts_pkg::CTX_W),
      .DEPTH (SLOTS)
   ) u_context_ram (
      .clock   (clock),
      .wr_en   (ctx_wr_en),
      .wr_addr (ctx_wr_addr),
      .wr_data (ctx_wr_data),
      .rd_en   (ctx_rd_en),
      .rd_addr (ctx_rd_addr),
      .rd_data (ctx_rd_data)
   );

   // operation decode, round-robin scan and state write-back
   rrts_seq #(
      .SLOTS (SLOTS)
   ) u_seq (
      .clock       (clock),
      .reset       (reset),
      .op_valid    (req_tvalid),
      .op_ready    (req_tready),
      .op_func     (req_tuser[1:0]),
      .op_context  (req_tdata),
      .st_wr_en    (st_wr_en),
      .st_wr_addr  (st_wr_addr),
      .st_wr_data  (st_wr_data),
      .st_rd_en    (st_rd_en),
      .st_rd_addr  (st_rd_addr),
      .st_rd_data  (st_rd_data),
      .ctx_wr_en   (ctx_wr_en),
      .ctx_wr_addr (ctx_wr_addr),
      .ctx_wr_data (ctx_wr_data),
      .ctx_rd_en   (ctx_rd_en),
      .ctx_rd_addr (ctx_rd_addr),
      .ctx_rd_data (ctx_rd_data),
      .res_valid   (res_valid),
      .res_take    (res_take),
      .res         (res)
   );

   // the register takes a new result when empty or draining this cycle
   assign res_take = !out_valid_ff || rsp_tready;

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in = out_ff;
      if (res_valid && res_take) begin
         out_valid_in = 1'b1;
         out_in = res;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   // result beat packing
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata = {7'd0, out_ff.new_context, out_ff.new_slot,
                       out_ff.old_slot, out_ff.old_valid};
   assign rsp_tuser = {5'd0, out_ff.status};

endmodule
